/* rtl/core/glam_pkg.sv */
package glam_pkg;

   localparam int NUM_THR = 6;
   localparam int THR_W = 10;
   localparam int SAMPLE_W = 10;
   localparam int LEVEL_W = 3;
   localparam int BAR_W = 7;
   localparam int CHAR_W = 7;
   localparam int IDX_W = 4;
   localparam int CSR_IDX_W = 3;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [LEVEL_W-1:0] FIRST_ALARM_LEVEL = 3'd2;

   localparam logic [THR_W-1:0] THR_RESET [NUM_THR] = '{
      10'h072, 10'h0cf, 10'h12c, 10'h18a, 10'h1e7, 10'h244
   };

   localparam logic [1:0] MSG_NONE  = 2'd0;
   localparam logic [1:0] MSG_CLEAR = 2'd1;
   localparam logic [1:0] MSG_GAS   = 2'd2;

   localparam logic [CHAR_W-1:0] TEXT_CLEAR [5] = '{
      7'h43, 7'h4c, 7'h45, 7'h41, 7'h52
   };

   localparam logic [CHAR_W-1:0] TEXT_GAS [12] = '{
      7'h47, 7'h41, 7'h53, 7'h20, 7'h44, 7'h45,
      7'h54, 7'h45, 7'h43, 7'h54, 7'h45, 7'h44
   };

   typedef struct packed {
      logic [BAR_W-1:0] bar;
      logic [1:0]       msg;
   } cmd_type;

   function automatic logic [BAR_W-1:0] bar_of(input logic [LEVEL_W-1:0] level);
      logic [BAR_W-1:0] bar;
      case (level)
         3'd0: bar = 7'h01;
         3'd1: bar = 7'h03;
         3'd2: bar = 7'h07;
         3'd3: bar = 7'h0f;
         3'd4: bar = 7'h1f;
         3'd5: bar = 7'h3f;
         default: bar = 7'h7f;
      endcase
      return bar;
   endfunction

   function automatic logic [IDX_W-1:0] msg_last_idx(input logic [1:0] msg);
      logic [IDX_W-1:0] idx;
      case (msg)
         MSG_CLEAR: idx = 4'd4;
         MSG_GAS:   idx = 4'd11;
         default:   idx = 4'd0;
      endcase
      return idx;
   endfunction

   function automatic logic [CHAR_W-1:0] char_at(input logic [1:0] msg,
                                                 input logic [IDX_W-1:0] idx);
      logic [CHAR_W-1:0] ch;
      ch = '0;
      case (msg)
         MSG_CLEAR: begin
            if (idx < 4'd5) begin
               ch = TEXT_CLEAR[idx[2:0]];
            end
         end
         MSG_GAS: begin
            if (idx < 4'd12) begin
               ch = TEXT_GAS[idx];
            end
         end
         default: ch = '0;
      endcase
      return ch;
   endfunction

endpackage

/* rtl/core/glam_front.sv */
module glam_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [glam_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [glam_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [glam_pkg::THR_W-1:0]      csr_wdata,
   output logic                            push_valid,
   input  logic                            push_ready,
   output glam_pkg::cmd_type               push_cmd
);
   import glam_pkg::*;

   logic [THR_W-1:0]   thr_ff [NUM_THR];
   logic [THR_W-1:0]   thr_in [NUM_THR];
   logic               gas_shown_ff;
   logic               gas_shown_in;
   logic               blink_ff;
   logic               blink_in;
   logic [LEVEL_W-1:0] level;
   logic [BAR_W-1:0]   bar_full;
   logic               accept;
   logic               alarm;

   assign csr_ready  = 1'b1;
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid & push_ready;

   always_comb begin
      for (int i = 0; i < NUM_THR; i++) begin
         thr_in[i] = thr_ff[i];
         if (csr_valid && (csr_index == CSR_IDX_W'(i))) begin
            thr_in[i] = csr_wdata;
         end
      end
   end

   always_comb begin
      level = LEVEL_W'(NUM_THR);
      for (int i = NUM_THR - 1; i >= 0; i--) begin
         if (req_sample <= thr_ff[i]) begin
            level = LEVEL_W'(i);
         end
      end
   end

   assign bar_full = bar_of(level);
   assign alarm    = (level >= FIRST_ALARM_LEVEL);

   always_comb begin
      gas_shown_in = gas_shown_ff;
      blink_in     = blink_ff;
      push_cmd.bar = bar_full;
      push_cmd.msg = MSG_NONE;
      if (alarm) begin
         if (blink_ff) begin
            push_cmd.bar = '0;
         end
         blink_in = ~blink_ff;
         if (!gas_shown_ff) begin
            gas_shown_in = 1'b1;
            push_cmd.msg = MSG_GAS;
         end
      end else if (gas_shown_ff) begin
         gas_shown_in = 1'b0;
         push_cmd.msg = MSG_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THR_RESET;
         gas_shown_ff <= 1'b0;
         blink_ff     <= 1'b0;
      end else begin
         thr_ff <= thr_in;
         if (accept) begin
            gas_shown_ff <= gas_shown_in;
            blink_ff     <= blink_in;
         end
      end
   end

endmodule

/* rtl/core/glam_queue.sv */
module glam_queue #(
   parameter int DEPTH = glam_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  glam_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output glam_pkg::cmd_type pop_cmd
);
   import glam_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/core/glam_back.sv */
module glam_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   output logic                         cmd_ready,
   input  glam_pkg::cmd_type            cmd,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [glam_pkg::BAR_W-1:0]   rsp_led_bar,
   output logic                         rsp_has_char,
   output logic [glam_pkg::CHAR_W-1:0]  rsp_char_code,
   output logic                         rsp_clear_display,
   output logic                         rsp_last
);
   import glam_pkg::*;

   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic             is_last;
   logic             has_msg;
   logic             fire;

   assign has_msg = (cmd.msg != MSG_NONE);
   assign is_last = (idx_ff == msg_last_idx(cmd.msg));
   assign fire    = rsp_valid & rsp_ready;

   assign rsp_valid         = cmd_valid;
   assign cmd_ready         = fire & is_last;
   assign rsp_led_bar       = cmd.bar;
   assign rsp_has_char      = has_msg;
   assign rsp_char_code     = char_at(cmd.msg, idx_ff);
   assign rsp_clear_display = has_msg & (idx_ff == '0);
   assign rsp_last          = is_last;

   always_comb begin
      idx_in = idx_ff;
      if (fire) begin
         idx_in = is_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

/* rtl/core/gas_level_alarm_monitor_top.sv */
// A sample's first result is offered at the earliest in the cycle after it is accepted
// (the command queue registers it), later while earlier samples are still being played out.
// The back end gives one result per cycle while rsp_ready is high; a sample gives 1, 5 or 12
// results, and the front end keeps accepting samples while the back end plays them out.
// The command queue between the two holds QUEUE_DEPTH classified samples; the input stalls
// only while it is full. Reset (synchronous, active high) restores the default thresholds,
// the clear state, the blink phase and the back end's character index, and empties the queue.
module gas_level_alarm_monitor_top #(
   parameter int QUEUE_DEPTH = glam_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [glam_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [glam_pkg::BAR_W-1:0]      rsp_led_bar,
   output logic                            rsp_has_char,
   output logic [glam_pkg::CHAR_W-1:0]     rsp_char_code,
   output logic                            rsp_clear_display,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [glam_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [glam_pkg::THR_W-1:0]      csr_wdata
);
   import glam_pkg::*;

   cmd_type push_cmd;
   cmd_type pop_cmd;
   logic    push_valid;
   logic    push_ready;
   logic    pop_valid;
   logic    pop_ready;

   glam_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   glam_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   glam_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (pop_valid),
      .cmd_ready         (pop_ready),
      .cmd               (pop_cmd),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_led_bar       (rsp_led_bar),
      .rsp_has_char      (rsp_has_char),
      .rsp_char_code     (rsp_char_code),
      .rsp_clear_display (rsp_clear_display),
      .rsp_last          (rsp_last)
   );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import glam_pkg::*;

   localparam logic [CSR_IDX_W-1:0] IDX_FIRST_THR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] IDX_SPARE_LO  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] IDX_SPARE_HI  = 3'd7;
   localparam int ALARM_FROM_LEVEL = 2;

   typedef struct packed {
      logic [BAR_W-1:0]  led_bar;
      logic              has_char;
      logic [CHAR_W-1:0] char_code;
      logic              clear_display;
      logic              last;
   } panel_type;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      bit                  typed;
      logic [BAR_W-1:0]    bar;
      logic [1:0]          msg;
   } sample_step_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [SAMPLE_W-1:0]  req_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [BAR_W-1:0]     rsp_led_bar;
   logic                 rsp_has_char;
   logic [CHAR_W-1:0]    rsp_char_code;
   logic                 rsp_clear_display;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [THR_W-1:0]     csr_wdata = '0;

   logic [THR_W-1:0] thr_now [NUM_THR] = '{10'd114, 10'd207, 10'd300, 10'd394, 10'd487, 10'd580};
   logic [THR_W-1:0] thr_plan [NUM_THR];
   logic             gas_now = 1'b0;
   logic             phase_now = 1'b0;
   panel_type        pending_panel [$];
   int               errors = 0;
   bit               calm = 1'b0;
   bit               hold_rsp = 1'b0;

   sample_step_type step_table [22] = '{
      '{10'd0,    1'b1, 7'h01, MSG_NONE},
      '{10'd114,  1'b1, 7'h01, MSG_NONE},
      '{10'd115,  1'b1, 7'h03, MSG_NONE},
      '{10'd207,  1'b1, 7'h03, MSG_NONE},
      '{10'd208,  1'b1, 7'h07, MSG_GAS},
      '{10'd300,  1'b1, 7'h00, MSG_NONE},
      '{10'd301,  1'b1, 7'h0f, MSG_NONE},
      '{10'd394,  1'b1, 7'h00, MSG_NONE},
      '{10'd395,  1'b1, 7'h1f, MSG_NONE},
      '{10'd487,  1'b1, 7'h00, MSG_NONE},
      '{10'd488,  1'b1, 7'h3f, MSG_NONE},
      '{10'd580,  1'b1, 7'h00, MSG_NONE},
      '{10'd581,  1'b1, 7'h7f, MSG_NONE},
      '{10'd1023, 1'b1, 7'h00, MSG_NONE},
      '{10'd1023, 1'b1, 7'h7f, MSG_NONE},
      '{10'd100,  1'b1, 7'h01, MSG_CLEAR},
      '{10'd1023, 1'b1, 7'h00, MSG_GAS},
      '{10'd200,  1'b1, 7'h03, MSG_CLEAR},
      '{10'h2aa,  1'b1, 7'h7f, MSG_GAS},
      '{10'h155,  1'b1, 7'h00, MSG_NONE},
      '{10'd115,  1'b0, 7'h00, MSG_NONE},
      '{10'd512,  1'b0, 7'h00, MSG_NONE}
   };

   gas_level_alarm_monitor_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_led_bar       (rsp_led_bar),
      .rsp_has_char      (rsp_has_char),
      .rsp_char_code     (rsp_char_code),
      .rsp_clear_display (rsp_clear_display),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic void classify_sample(input logic [SAMPLE_W-1:0] s,
                                           output logic [BAR_W-1:0] bar,
                                           output logic [1:0] msg);
      int level;
      logic [BAR_W-1:0] full;
      level = NUM_THR;
      for (int k = NUM_THR - 1; k >= 0; k--) begin
         if (s <= thr_now[k]) begin
            level = k;
         end
      end
      full = BAR_W'((1 << (level + 1)) - 1);
      msg = MSG_NONE;
      if (level < ALARM_FROM_LEVEL) begin
         bar = full;
         if (gas_now) begin
            gas_now = 1'b0;
            msg = MSG_CLEAR;
         end
      end else begin
         bar = phase_now ? '0 : full;
         phase_now = ~phase_now;
         if (!gas_now) begin
            gas_now = 1'b1;
            msg = MSG_GAS;
         end
      end
   endfunction

   function automatic void queue_panel(input logic [BAR_W-1:0] bar, input logic [1:0] msg);
      string text;
      byte ch;
      panel_type p;
      if (msg == MSG_NONE) begin
         p = '{bar, 1'b0, '0, 1'b0, 1'b1};
         pending_panel.push_back(p);
         return;
      end
      if (msg == MSG_CLEAR) begin
         text = "CLEAR";
      end else begin
         text = "GAS DETECTED";
      end
      for (int k = 0; k < text.len(); k++) begin
         ch = text[k];
         p = '{bar, 1'b1, ch[CHAR_W-1:0], k == 0, k == text.len() - 1};
         pending_panel.push_back(p);
      end
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int t;
      if ($urandom_range(0, 3) == 0) begin
         return SAMPLE_W'($urandom_range(0, 1023));
      end
      t = int'(thr_now[$urandom_range(0, NUM_THR - 1)]) + int'($urandom_range(0, 2)) - 1;
      if (t < 0) t = 0;
      if (t > 1023) t = 1023;
      return SAMPLE_W'(t);
   endfunction

   task automatic offer_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                               input logic [BAR_W-1:0] t_bar, input logic [1:0] t_msg);
      logic [BAR_W-1:0] bar;
      logic [1:0] msg;
      req_valid <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
      classify_sample(s, bar, msg);
      if (typed) begin
         bar = t_bar;
         msg = t_msg;
      end
      queue_panel(bar, msg);
      if (!calm && !hold_rsp && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_panel.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx < NUM_THR) begin
         thr_now[idx] = data;
      end
   endtask

   task automatic program_thresholds(input bit stray);
      for (int k = 0; k < NUM_THR; k++) begin
         csr_write(IDX_FIRST_THR + CSR_IDX_W'(k), thr_plan[k]);
      end
      if (stray) begin
         csr_write(IDX_SPARE_LO, THR_W'($urandom_range(0, 1023)));
         csr_write(IDX_SPARE_HI, THR_W'($urandom_range(0, 1023)));
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(input int count);
      for (int n = 0; n < count; n++) begin
         offer_sample(pick_sample(), 1'b0, '0, MSG_NONE);
      end
      settle();
   endtask

   always @(posedge clock) begin : check_rsp
      panel_type seen;
      panel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{rsp_led_bar, rsp_has_char, rsp_char_code, rsp_clear_display, rsp_last};
         if (pending_panel.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction bar=%h has=%b char=%h clr=%b last=%b",
                     $time, seen.led_bar, seen.has_char, seen.char_code,
                     seen.clear_display, seen.last);
         end else begin
            want = pending_panel.pop_front();
            if (seen !== want) begin
               errors++;
               $display({"%0t: mismatch expected bar=%h has=%b char=%h clr=%b last=%b, ",
                         "actual bar=%h has=%b char=%h clr=%b last=%b"},
                        $time, want.led_bar, want.has_char, want.char_code,
                        want.clear_display, want.last, seen.led_bar, seen.has_char,
                        seen.char_code, seen.clear_display, seen.last);
            end
         end
      end
   end

   initial begin : rsp_side
      wait (!reset);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (80) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int vals [$];
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (step_table[i]) begin
         offer_sample(step_table[i].sample, step_table[i].typed,
                      step_table[i].bar, step_table[i].msg);
      end
      settle();

      thr_plan = '{default: 10'h000};
      program_thresholds(1'b1);
      random_phase(30);

      thr_plan = '{default: 10'h3ff};
      program_thresholds(1'b0);
      random_phase(30);

      foreach (thr_plan[k]) thr_plan[k] = THR_W'($urandom_range(0, 1023));
      program_thresholds(1'b1);
      random_phase(40);

      vals.delete();
      repeat (NUM_THR) vals.push_back($urandom_range(0, 1023));
      vals.sort();
      foreach (thr_plan[k]) thr_plan[k] = THR_W'(vals[k]);
      program_thresholds(1'b0);
      hold_rsp = 1'b1;
      random_phase(40);

      foreach (thr_plan[k]) thr_plan[k] = THR_W'($urandom_range(0, 1023));
      program_thresholds(1'b1);
      random_phase(40);

      thr_plan = '{10'd114, 10'd207, 10'd300, 10'd394, 10'd487, 10'd580};
      program_thresholds(1'b0);
      calm = 1'b1;
      random_phase(50);

      repeat (20) @(posedge clock);
      if (errors == 0 && pending_panel.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
